// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/aluasf_pkg.sv
// ---------------------------------------------------------------------------
// aluasf_pkg
// types and constants of the add/sub alu with flags
// ---------------------------------------------------------------------------
package aluasf_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_ADD8  = 3'd0;
  localparam cmd_t CMD_ADC8  = 3'd1;
  localparam cmd_t CMD_SUB8  = 3'd2;
  localparam cmd_t CMD_SBC8  = 3'd3;
  localparam cmd_t CMD_CP8   = 3'd4;
  localparam cmd_t CMD_ADD16 = 3'd5;
  localparam cmd_t CMD_ADC16 = 3'd6;
  localparam cmd_t CMD_SBC16 = 3'd7;

  // flag byte layout: S Z 5 H 3 P N C
  localparam int FLAG_C  = 0;
  localparam int FLAG_N  = 1;
  localparam int FLAG_P  = 2;
  localparam int FLAG_B3 = 3;
  localparam int FLAG_H  = 4;
  localparam int FLAG_B5 = 5;
  localparam int FLAG_Z  = 6;
  localparam int FLAG_S  = 7;

  // flags that 16-bit add leaves untouched
  localparam logic [7:0] KEEP_SZP = 8'hC4;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [7:0]  flags_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags_out;
  } out_item_t;

endpackage

// File: rtl/aluasf_if.sv
// ---------------------------------------------------------------------------
// aluasf_if
// valid/ready channels for alu operations and alu results
// ---------------------------------------------------------------------------
interface aluasf_in_if;
  logic              valid;
  logic              ready;
  aluasf_pkg::cmd_t  command;
  logic [15:0]       operand_a;
  logic [15:0]       operand_b;
  logic [7:0]        flags_in;

  modport source (output valid, command, operand_a, operand_b, flags_in, input ready);
  modport sink   (input valid, command, operand_a, operand_b, flags_in, output ready);
endinterface

interface aluasf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic [7:0]  flags_out;

  modport source (output valid, result, flags_out, input ready);
  modport sink   (input valid, result, flags_out, output ready);
endinterface

// File: rtl/aluasf_core.sv
// ---------------------------------------------------------------------------
// aluasf_core
// combinational adder/subtractor and flag generation for one word
// ---------------------------------------------------------------------------
module aluasf_core (
  input  aluasf_pkg::in_item_t  item,
  output aluasf_pkg::out_item_t res
);
  import aluasf_pkg::*;

  logic        cin;
  logic        sub8;
  logic        cin8;
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [8:0]  s9;
  logic [7:0]  r8;
  logic        v8;
  logic [7:0]  f8;
  logic        sub16;
  logic        cin16;
  logic [16:0] s17;
  logic [15:0] r16;
  logic        v16;

  always_comb begin
    cin   = item.flags_in[FLAG_C];
    a8    = item.operand_a[7:0];
    b8    = item.operand_b[7:0];
    sub8  = (item.command == CMD_SUB8) || (item.command == CMD_SBC8) ||
            (item.command == CMD_CP8);
    cin8  = ((item.command == CMD_ADC8) || (item.command == CMD_SBC8)) ? cin : 1'b0;
    sub16 = (item.command == CMD_SBC16);
    cin16 = ((item.command == CMD_ADC16) || (item.command == CMD_SBC16)) ? cin : 1'b0;

    // byte path, bit 8 is carry or borrow
    if (sub8) begin
      s9 = {1'b0, a8} - {1'b0, b8} - {8'd0, cin8};
    end else begin
      s9 = {1'b0, a8} + {1'b0, b8} + {8'd0, cin8};
    end
    r8 = s9[7:0];
    v8 = sub8 ? ((a8[7] ^ b8[7]) & (a8[7] ^ r8[7]))
              : (~(a8[7] ^ b8[7]) & (a8[7] ^ r8[7]));
    f8 = {r8[7], (r8 == 8'd0), r8[5], (a8[4] ^ b8[4] ^ r8[4]), r8[3], v8, sub8, s9[8]};

    // word path, bit 16 is carry or borrow
    if (sub16) begin
      s17 = {1'b0, item.operand_a} - {1'b0, item.operand_b} - {16'd0, cin16};
    end else begin
      s17 = {1'b0, item.operand_a} + {1'b0, item.operand_b} + {16'd0, cin16};
    end
    r16 = s17[15:0];
    v16 = sub16 ? ((item.operand_a[15] ^ item.operand_b[15]) & (item.operand_a[15] ^ r16[15]))
                : (~(item.operand_a[15] ^ item.operand_b[15]) &
                   (item.operand_a[15] ^ r16[15]));

    case (item.command)
      CMD_ADD8, CMD_ADC8, CMD_SUB8, CMD_SBC8: begin
        res.result    = {8'd0, r8};
        res.flags_out = f8;
      end
      CMD_CP8: begin
        // undocumented bits follow the compared operand
        res.result    = item.operand_a;
        res.flags_out = f8;
        res.flags_out[FLAG_B5] = b8[5];
        res.flags_out[FLAG_B3] = b8[3];
      end
      CMD_ADD16: begin
        res.result    = r16;
        res.flags_out = (item.flags_in & KEEP_SZP) |
                        {2'b00, r16[13], r16[12], r16[11], 2'b00, s17[16]};
      end
      CMD_ADC16, CMD_SBC16: begin
        res.result    = r16;
        res.flags_out = {r16[15], (r16 == 16'd0), r16[13], r16[12], r16[11], v16,
                         sub16, s17[16]};
      end
      default: begin
        res.result    = r16;
        res.flags_out = 8'd0;
      end
    endcase
  end

endmodule

// File: rtl/alu_add_sub_with_flags.sv
// ---------------------------------------------------------------------------
// alu_add_sub_with_flags
// 8/16-bit add, subtract and compare with processor-style flag byte
// ---------------------------------------------------------------------------
// Takes one operation per clock while input ready is high and returns one word of
// result and flags per operation, in order. An accepted word sits in the input
// register while the adder and flag logic work on it, then lands in the result
// register when that register is empty or being drained, which raises out valid.
// Throughput is one word per cycle while out ready is high, set by the single
// pass through the adder between the two registers.
// While a finished result waits with out ready low, input ready stays high
// only as long as the input register is empty; with both registers full it
// drops until the result is taken. The block holds no state between words, so
// reset only clears the valid bits.
module alu_add_sub_with_flags (
  input  logic           clk,
  input  logic           rst_n,
  aluasf_in_if.sink      in_ch,
  aluasf_out_if.source   out_ch
);
  import aluasf_pkg::*;

  // input stage
  logic      in_vld_r;
  in_item_t  in_item_r;
  // result stage
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  // stage advance enables
  logic      out_adv;
  logic      in_adv;

  aluasf_core u_core (
    .item (in_item_r),
    .res  (out_item_nxt)
  );

  // result register can take a word when empty or being drained
  assign out_adv     = !out_vld_r || out_ch.ready;
  // input register can take a word when empty or moving to the result stage
  assign in_adv      = !in_vld_r || out_adv;
  assign in_ch.ready = in_adv;

  assign out_ch.valid     = out_vld_r;
  assign out_ch.result    = out_item_r.result;
  assign out_ch.flags_out = out_item_r.flags_out;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_adv && in_ch.valid) begin
      in_item_r.command   <= in_ch.command;
      in_item_r.operand_a <= in_ch.operand_a;
      in_item_r.operand_b <= in_ch.operand_b;
      in_item_r.flags_in  <= in_ch.flags_in;
    end
    if (out_adv && in_vld_r) begin
      out_item_r <= out_item_nxt;
    end
  end

`include "assert_macros.svh"

  // both stages full and output stalled: no room for a new word
  `AST_SAME(a_full_blocks, clk, rst_n, in_vld_r && out_vld_r && !out_ch.ready, !in_ch.ready, "input ready while both stages are full")
  // an accepted word always lands in the input stage
  `AST_NEXT(a_accept_lands, clk, rst_n, in_ch.valid && in_ch.ready, in_vld_r, "accepted word lost before input stage")
  // a word in the input stage that advances shows up as a result
  `AST_NEXT(a_stage_moves, clk, rst_n, in_vld_r && out_adv, out_vld_r, "word lost between input and result stage")

endmodule
